// File: sv/dpf_pkg.sv
// Shared constants and elaboration-time helpers for the dew point block.
package dpf_pkg;

  localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;
  localparam int DEW_MIN = -20000;
  localparam int DEW_MAX = 13000;
  localparam int T_OFFSET_CENTI = 4500;
  localparam logic [63:0] SENSOR_FULL = 64'd65535;

  // log2(1 + i/2^lt) in Q.f by repeated squaring; evaluated at elaboration only
  function automatic logic [63:0] log_lut(input int unsigned i, input int unsigned lt,
                                          input int unsigned f);
    logic [63:0] y;
    logic [63:0] r;
    int k;
    if (i >= (32'd1 << lt)) begin
      return 64'd1 << f;
    end
    r = 64'd0;
    y = 64'((32'd1 << lt) + i) << (30 - lt);
    for (k = 1; k <= 32; k++) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        r = r | (64'd1 << (32 - k));
      end
    end
    return (r + (64'd1 << (31 - f))) >> (32 - f);
  endfunction

  // log2 of the full-scale word 65535 in Q.f, same interpolation as the datapath
  function automatic logic [63:0] log2_max(input int unsigned lt, input int unsigned f);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] rem;
    a   = log_lut((32'd1 << lt) - 1, lt, f);
    b   = 64'd1 << f;
    rem = (64'd1 << (15 - lt)) - 64'd1;
    return (64'd15 << f) + a + (((b - a) * rem) >> (15 - lt));
  endfunction

  // Quotient estimate for x/65535; low by at most one
  function automatic logic [63:0] div65535_est(input logic [63:0] x);
    return (x + (x >> 16) + (x >> 32)) >> 16;
  endfunction

  // One compare-and-subtract correction of the estimate
  function automatic logic [63:0] div65535_fix(input logic [63:0] x, input logic [63:0] q);
    logic [63:0] r;
    r = x - ((q << 16) - q);
    return (r >= SENSOR_FULL) ? q + 64'd1 : q;
  endfunction

endpackage

// File: sv/dpf_if.sv
// Valid/ready channel interfaces for sensor words in and dew point results out.
interface dpf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [15:0] raw_humidity;
  modport source (output valid, output raw_temperature, output raw_humidity, input ready);
  modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface dpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dew_point_centi;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic               invalid;
  modport source (output valid, output dew_point_centi, output temperature_centi,
                  output humidity_centi, output invalid, input ready);
  modport sink   (input valid, input dew_point_centi, input temperature_centi,
                  input humidity_centi, input invalid, output ready);
endinterface

// File: sv/dew_point_from_sensor_words.sv
// Dew point from raw sensor words (base-10 Magnus formula), fixed-point pipeline.
// The pipeline is two bit-per-cell divider chains (2F+10 and 2F+12 cells) plus 8 stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits unread.
// Reset (rst_n low, synchronous) clears every stage valid bit; no clearing pass.
module dew_point_from_sensor_words #(
  parameter int FRAC_BITS      = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  dpf_in_if.sink    in_ch,
  dpf_out_if.source out_ch
);
  localparam int F      = FRAC_BITS;
  localparam int LTB    = LOG_TABLE_BITS;
  localparam int RB     = 15 - LTB;
  localparam int TQ_W   = F + 9;
  localparam int XQ_W   = F + 25;
  localparam int LOG_W  = F + 5;
  localparam int NUM1_W = 2 * F + 10;
  localparam int DEN1_W = F + 9;
  localparam int E_W    = F + 4;
  localparam int MUL_W  = LOG_W + 31;
  localparam int G_W    = F + 5;
  localparam int NUM2_W = 2 * F + 12;
  localparam int DEN2_W = F + 4;
  localparam int D_W    = F + 11;
  localparam int R_W    = D_W + 7 - F;
  localparam int SIDE1_W = 1 + LOG_W + 15 + 14 + 1;
  localparam int SIDE2_W = 1 + 15 + 14 + 1;

  localparam logic [DEN1_W-1:0] B_Q =
      DEN1_W'(((64'd2373 << F) + 64'd5) / 64'd10);
  localparam logic signed [G_W:0] A_Q = (G_W+1)'(64'd15 << (F - 1));
  localparam logic [LOG_W-1:0] LOG_MAX = LOG_W'(dpf_pkg::log2_max(LTB, F));
  localparam logic [TQ_W-1:0] T_OFS_Q = TQ_W'(64'd45 << F);

  // Pipeline advances whenever the output register is free or being emptied
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // log2(1+x) table, built at elaboration
  logic [F:0] lut [0:2**LTB];
  for (genvar gi = 0; gi <= 2**LTB; gi++) begin : g_lut
    localparam logic [F:0] LUT_V = (F+1)'(dpf_pkg::log_lut(gi, LTB, F));
    assign lut[gi] = LUT_V;
  end

  // Stage 0: capture the transfer
  logic        s0_v_r;
  logic [15:0] s0_rt_r, s0_rh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_rt_r <= in_ch.raw_temperature;
      s0_rh_r <= in_ch.raw_humidity;
    end
  end

  // Stage 1: scale by constants, estimate the /65535 quotients, normalise humidity
  logic [30:0]      xt_nxt;
  logic [29:0]      xh_nxt;
  logic [XQ_W-1:0]  xq_nxt;
  logic [3:0]       lead;
  logic [15:0]      mant;
  logic [LTB-1:0]   idx;
  logic [F:0]       lut_a, lut_b;

  always_comb begin
    xt_nxt = 31'(s0_rt_r) * 31'd17500 + 31'd32767;
    xh_nxt = 30'(s0_rh_r) * 30'd10000 + 30'd32767;
    xq_nxt = (XQ_W'(s0_rt_r) * XQ_W'(175) << F) + XQ_W'(32767);
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (s0_rh_r[i]) lead = 4'(i);
    end
    mant  = s0_rh_r << (4'd15 - lead);
    idx   = mant[14:RB];
    lut_a = lut[{1'b0, idx}];
    lut_b = lut[(LTB+1)'(idx) + (LTB+1)'(1)];
  end

  logic             s1_v_r;
  logic [30:0]      s1_xt_r;
  logic [29:0]      s1_xh_r;
  logic [XQ_W-1:0]  s1_xq_r;
  logic [14:0]      s1_qt_r;
  logic [13:0]      s1_qh_r;
  logic [F+7:0]     s1_qq_r;
  logic [3:0]       s1_p_r;
  logic [F:0]       s1_a_r, s1_db_r;
  logic [RB-1:0]    s1_rem_r;
  logic             s1_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_xt_r  <= xt_nxt;
      s1_xh_r  <= xh_nxt;
      s1_xq_r  <= xq_nxt;
      s1_qt_r  <= 15'(dpf_pkg::div65535_est(64'(xt_nxt)));
      s1_qh_r  <= 14'(dpf_pkg::div65535_est(64'(xh_nxt)));
      s1_qq_r  <= (F+8)'(dpf_pkg::div65535_est(64'(xq_nxt)));
      s1_p_r   <= lead;
      s1_a_r   <= lut_a;
      s1_db_r  <= lut_b - lut_a;
      s1_rem_r <= mant[RB-1:0];
      s1_inv_r <= (s0_rh_r == 16'd0);
    end
  end

  // Stage 2: correct quotients, interpolation product
  logic               s2_v_r;
  logic signed [14:0] s2_tc_r;
  logic        [13:0] s2_hc_r;
  logic signed [TQ_W-1:0] s2_tq_r;
  logic [F+RB:0]      s2_prod_r;
  logic [3:0]         s2_p_r;
  logic [F:0]         s2_a_r;
  logic               s2_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_tc_r   <= 15'(dpf_pkg::div65535_fix(64'(s1_xt_r), 64'(s1_qt_r)))
                   - 15'(dpf_pkg::T_OFFSET_CENTI);
      s2_hc_r   <= 14'(dpf_pkg::div65535_fix(64'(s1_xh_r), 64'(s1_qh_r)));
      s2_tq_r   <= TQ_W'(dpf_pkg::div65535_fix(64'(s1_xq_r), 64'(s1_qq_r))) - T_OFS_Q;
      s2_prod_r <= (F+RB+1)'(s1_db_r) * (F+RB+1)'(s1_rem_r);
      s2_p_r    <= s1_p_r;
      s2_a_r    <= s1_a_r;
      s2_inv_r  <= s1_inv_r;
    end
  end

  // Stage 3: log magnitude, operands of A*T/(B+T)
  logic [TQ_W-1:0]  tmag;
  logic [LOG_W-1:0] log2_h;
  logic             s3_v_r;
  logic [NUM1_W-1:0] s3_num_r;
  logic [DEN1_W-1:0] s3_den_r;
  logic [SIDE1_W-1:0] s3_side_r;

  always_comb begin
    tmag   = s2_tq_r[TQ_W-1] ? TQ_W'(-s2_tq_r) : TQ_W'(s2_tq_r);
    log2_h = (LOG_W'(s2_p_r) << F) + LOG_W'(s2_a_r) + LOG_W'(s2_prod_r >> RB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_num_r  <= ((NUM1_W'(tmag) << 4) - NUM1_W'(tmag)) << (F - 1);
      s3_den_r  <= B_Q + DEN1_W'(s2_tq_r);
      s3_side_r <= {s2_tq_r[TQ_W-1], LOG_MAX - log2_h, s2_tc_r, s2_hc_r, s2_inv_r};
    end
  end

  // Divider chain one: e = A*T/(B+T)
  logic               d1_v;
  logic [NUM1_W-1:0]  d1_q;
  logic [SIDE1_W-1:0] d1_side;

  dpf_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W), .SIDE_W(SIDE1_W)) u_div_e (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_in(s3_v_r), .num(s3_num_r), .den(s3_den_r), .side_in(s3_side_r),
    .valid_out(d1_v), .quo(d1_q), .side_out(d1_side)
  );

  // Stage 4: sign of e, log10 scaling product
  logic [E_W-1:0]     e_mag;
  logic               s4_v_r;
  logic signed [E_W-1:0] s4_e_r;
  logic [MUL_W-1:0]   s4_mul_r;
  logic [SIDE2_W-2:0] s4_pass_r;

  assign e_mag = d1_q[E_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_e_r    <= d1_side[SIDE1_W-1] ? E_W'(-e_mag) : E_W'(e_mag);
      s4_mul_r  <= MUL_W'(d1_side[SIDE1_W-2 -: LOG_W]) * MUL_W'(dpf_pkg::LOG10_2_Q32);
      s4_pass_r <= d1_side[SIDE2_W-2:0];
    end
  end

  // Stage 5: gamma = log10 + e
  logic [LOG_W-2:0]   l10_mag;
  logic               s5_v_r;
  logic signed [G_W-1:0] s5_g_r;
  logic [SIDE2_W-2:0] s5_pass_r;

  assign l10_mag = (LOG_W-1)'((s4_mul_r + (MUL_W'(1) << 31)) >> 32);

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_g_r    <= G_W'(s4_e_r) - G_W'(l10_mag);
      s5_pass_r <= s4_pass_r;
    end
  end

  // Stage 6: operands of B*gamma/(A-gamma)
  logic [G_W-1:0]     g_mag;
  logic signed [G_W:0] den2_full;
  logic               s6_v_r;
  logic [NUM2_W-1:0]  s6_num_r;
  logic [DEN2_W-1:0]  s6_den_r;
  logic [SIDE2_W-1:0] s6_side_r;

  always_comb begin
    g_mag     = s5_g_r[G_W-1] ? G_W'(-s5_g_r) : G_W'(s5_g_r);
    den2_full = A_Q - (G_W+1)'(s5_g_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_num_r  <= NUM2_W'(B_Q) * NUM2_W'(g_mag);
      s6_den_r  <= den2_full[DEN2_W-1:0];
      s6_side_r <= {s5_g_r[G_W-1], s5_pass_r};
    end
  end

  // Divider chain two: D = B*gamma/(A-gamma)
  logic               d2_v;
  logic [NUM2_W-1:0]  d2_q;
  logic [SIDE2_W-1:0] d2_side;

  dpf_div #(.NUM_W(NUM2_W), .DEN_W(DEN2_W), .SIDE_W(SIDE2_W)) u_div_d (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_in(s6_v_r), .num(s6_num_r), .den(s6_den_r), .side_in(s6_side_r),
    .valid_out(d2_v), .quo(d2_q), .side_out(d2_side)
  );

  // Stage 7: scale to hundredths, round half away from zero, saturate; invalid input gives DEW_MIN
  logic [D_W-1:0]   d_mag;
  logic [D_W+6:0]   d100;
  logic [R_W-1:0]   rnd;
  logic signed [15:0] dew_nxt;

  always_comb begin
    d_mag = d2_q[D_W-1:0];
    d100  = ((D_W+7)'(d_mag) << 6) + ((D_W+7)'(d_mag) << 5) + ((D_W+7)'(d_mag) << 2);
    rnd   = R_W'((d100 + ((D_W+7)'(1) << (F - 1))) >> F);
    if (d2_side[0]) begin
      dew_nxt = 16'(dpf_pkg::DEW_MIN);
    end else if (d2_side[SIDE2_W-1]) begin
      dew_nxt = (rnd > R_W'(-dpf_pkg::DEW_MIN)) ? 16'(dpf_pkg::DEW_MIN) : -16'(rnd);
    end else begin
      dew_nxt = (rnd > R_W'(dpf_pkg::DEW_MAX)) ? 16'(dpf_pkg::DEW_MAX) : 16'(rnd);
    end
  end

  // Output register: hold the result until it is transferred
  logic signed [15:0] out_dew_r;
  logic signed [14:0] out_tc_r;
  logic        [13:0] out_hc_r;
  logic               out_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_dew_r <= dew_nxt;
      out_tc_r  <= d2_side[29:15];
      out_hc_r  <= d2_side[14:1];
      out_inv_r <= d2_side[0];
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.dew_point_centi   = out_dew_r;
  assign out_ch.temperature_centi = out_tc_r;
  assign out_ch.humidity_centi    = out_hc_r;
  assign out_ch.invalid           = out_inv_r;
endmodule

// File: sv/dpf_div_cell.sv
// One restoring-division cell: develops one quotient bit and passes on.
module dpf_div_cell #(
  parameter int NUM_W  = 42,
  parameter int DEN_W  = 25,
  parameter int SIDE_W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid_in,
  input  logic [DEN_W+NUM_W:0]            acc_in,
  input  logic [DEN_W-1:0]                den_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            valid_out,
  output logic [DEN_W+NUM_W:0]            acc_out,
  output logic [DEN_W-1:0]                den_out,
  output logic [SIDE_W-1:0]               side_out
);
  localparam int AW = DEN_W + NUM_W + 1;
  localparam int RW = DEN_W + 1;

  logic [AW-1:0]     sh;
  logic [RW-1:0]     top;
  logic [RW-1:0]     diff;
  logic [AW-1:0]     acc_nxt;
  logic              valid_r;
  logic [AW-1:0]     acc_r;
  logic [DEN_W-1:0]  den_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    sh   = {acc_in[AW-2:0], 1'b0};
    top  = sh[AW-1:NUM_W];
    diff = top - {1'b0, den_in};
    if (top >= {1'b0, den_in}) begin
      acc_nxt = {diff, sh[NUM_W-1:1], 1'b1};
    end else begin
      acc_nxt = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= acc_nxt;
      den_r  <= den_in;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign acc_out   = acc_r;
  assign den_out   = den_r;
  assign side_out  = side_r;
endmodule

// File: sv/dpf_div.sv
// Pipelined unsigned divider built as a chain of one-bit cells.
module dpf_div #(
  parameter int NUM_W  = 42,
  parameter int DEN_W  = 25,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid_out,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);
  localparam int AW = DEN_W + NUM_W + 1;

  logic              v   [0:NUM_W];
  logic [AW-1:0]     acc [0:NUM_W];
  logic [DEN_W-1:0]  dn  [0:NUM_W];
  logic [SIDE_W-1:0] sd  [0:NUM_W];

  assign v[0]   = valid_in;
  assign acc[0] = {{(DEN_W+1){1'b0}}, num};
  assign dn[0]  = den;
  assign sd[0]  = side_in;

  for (genvar gi = 0; gi < NUM_W; gi++) begin : g_cell
    dpf_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (v[gi]),
      .acc_in   (acc[gi]),
      .den_in   (dn[gi]),
      .side_in  (sd[gi]),
      .valid_out(v[gi+1]),
      .acc_out  (acc[gi+1]),
      .den_out  (dn[gi+1]),
      .side_out (sd[gi+1])
    );
  end

  assign valid_out = v[NUM_W];
  assign quo       = acc[NUM_W][NUM_W-1:0];
  assign side_out  = sd[NUM_W];
endmodule
